FILE: sv/scp_pkg.sv
// Package for the skyline contour place unit: sizes, status codes, request codes
// and cell rewrite selects. No dependencies.
`timescale 1ns / 1ps
package scp_pkg;
  localparam int unsigned MaxSegmentsDef = 64;
  localparam int unsigned CoordBitsDef   = 16;

  localparam logic       ReqClear = 1'b0;
  localparam logic       ReqPlace = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // Cell rewrite selects
  typedef logic [3:0] cell_sel_t;
  localparam cell_sel_t SelHold    = 4'd0;
  localparam cell_sel_t SelP1      = 4'd1;  // take previous cell
  localparam cell_sel_t SelP2      = 4'd2;  // take cell two back
  localparam cell_sel_t SelN1      = 4'd3;  // take next cell
  localparam cell_sel_t SelBlock   = 4'd4;  // the placed block
  localparam cell_sel_t SelOwnL    = 4'd5;  // own left piece, ends at xl
  localparam cell_sel_t SelOwnR    = 4'd6;  // own right piece, starts at xr
  localparam cell_sel_t SelRightP1 = 4'd7;  // right piece of previous cell
  localparam cell_sel_t SelRightP2 = 4'd8;  // right piece of cell two back
endpackage

FILE: sv/scp_cell.sv
// One segment cell of the contour row: holds start, end, height and a valid bit.
// Depends on scp_pkg. Classifies itself against the request and rewrites itself
// from its own value or a neighbor's (up to two places left, one place right).
`timescale 1ns / 1ps
module scp_cell #(
  parameter int unsigned CoordBits = scp_pkg::CoordBitsDef,
  parameter bit          IsFirst   = 1'b0   // cell 0 holds the reset segment
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 init_i,     // load reset value
  // request edges
  input  logic [CoordBits-1:0] xl_i,
  input  logic [CoordBits-1:0] xr_i,
  input  logic [CoordBits-1:0] top_i,
  // state of the neighbors
  input  logic [CoordBits-1:0] p1_start_i, p2_start_i,
  input  logic [CoordBits:0]   p1_end_i,   p2_end_i,
  input  logic [CoordBits-1:0] p1_height_i, p2_height_i,
  input  logic                 p1_valid_i, p2_valid_i,
  input  logic [CoordBits-1:0] n1_start_i,
  input  logic [CoordBits:0]   n1_end_i,
  input  logic [CoordBits-1:0] n1_height_i,
  input  logic                 n1_valid_i,
  input  scp_pkg::cell_sel_t   sel_i,      // write select
  output logic [CoordBits-1:0] start_o,
  output logic [CoordBits:0]   end_o,
  output logic [CoordBits-1:0] height_o,
  output logic                 valid_o,
  output logic                 hit_o       // overlaps [xl, xr)
);
  import scp_pkg::*;

  localparam logic [CoordBits:0] EndInit = IsFirst ? {1'b1, {CoordBits{1'b0}}} : '0;

  logic [CoordBits-1:0] start_q, start_d, height_q, height_d;
  logic [CoordBits:0]   end_q, end_d;
  logic                 valid_q, valid_d;

  assign start_o  = start_q;
  assign end_o    = end_q;
  assign height_o = height_q;
  assign valid_o  = valid_q;

  // classification against the request range
  assign hit_o = valid_q && (end_q > {1'b0, xl_i}) && (start_q < xr_i);

  // next value selection
  always_comb begin
    start_d = start_q; end_d = end_q; height_d = height_q; valid_d = valid_q;
    unique case (sel_i)
      SelHold: ;
      SelP1: begin
        start_d = p1_start_i; end_d = p1_end_i; height_d = p1_height_i;
        valid_d = p1_valid_i;
      end
      SelP2: begin
        start_d = p2_start_i; end_d = p2_end_i; height_d = p2_height_i;
        valid_d = p2_valid_i;
      end
      SelN1: begin
        start_d = n1_start_i; end_d = n1_end_i; height_d = n1_height_i;
        valid_d = n1_valid_i;
      end
      SelBlock: begin
        start_d = xl_i; end_d = {1'b0, xr_i}; height_d = top_i; valid_d = 1'b1;
      end
      SelOwnL: begin
        end_d = {1'b0, xl_i};
      end
      SelOwnR: begin
        start_d = xr_i;
      end
      SelRightP1: begin
        start_d = xr_i; valid_d = 1'b1;
        end_d = p1_end_i; height_d = p1_height_i;
      end
      SelRightP2: begin
        start_d = xr_i; valid_d = 1'b1;
        end_d = p2_end_i; height_d = p2_height_i;
      end
      default: ;
    endcase
    if (init_i) begin
      start_d = '0; height_d = '0;
      end_d = EndInit;
      valid_d = IsFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= IsFirst;
      start_q  <= '0;
      end_q    <= EndInit;
      height_q <= '0;
    end else begin
      valid_q  <= valid_d;
      start_q  <= start_d;
      end_q    <= end_d;
      height_q <= height_d;
    end
  end
endmodule

FILE: sv/skyline_contour_place_unit.sv
// Top level of the skyline contour place unit: a row of segment cells,
// a registered max reduction and the rewrite control. Depends on
// scp_pkg and scp_cell.
//
//  channel | dir | handshake            | payload
//  request | in  | start & !busy        | req_type_i x_left_i x_right_i block_height_i
//  result  | out | done_o (one cycle)   | base_y_o top_y_o status_o
//
// A place runs these steps after accept: classify cells, max of the covered
// heights (registered tree), rewrite of the cell row, result. A block that
// covers more segments than it leaves then removes the stale cells, at most
// MaxSegments-2, by left shifts. A clear or an empty range skips classify and max.
// busy is high from the cycle after accept until done_o, which comes with busy low.
// Reset loads one zero-height segment reaching to infinity. The receiver cannot stall.
`timescale 1ns / 1ps
module skyline_contour_place_unit #(
  parameter int unsigned MaxSegments = scp_pkg::MaxSegmentsDef,
  parameter int unsigned CoordBits   = scp_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  logic [CoordBits-1:0] x_left_i,
  input  logic [CoordBits-1:0] x_right_i,
  input  logic [CoordBits-1:0] block_height_i,
  output logic                 done_o,
  output logic [CoordBits-1:0] base_y_o,
  output logic [CoordBits-1:0] top_y_o,
  output logic [1:0]           status_o
);
  import scp_pkg::*;

  localparam int unsigned N  = MaxSegments;
  localparam int unsigned IW = $clog2(N + 1);
  localparam int unsigned W  = IW + 2;
  localparam int unsigned G  = 8;                 // tree leaf group
  localparam int unsigned NG = (N + G - 1) / G;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClass = 3'd1;
  localparam logic [2:0] StMax   = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StShift = 3'd4;
  localparam logic [2:0] StInit  = 3'd5;

  logic [2:0]           st_q, st_d;
  logic [CoordBits-1:0] xl_q, xr_q, hb_q, base_q, top_q;
  logic                 done_q, done_d;
  logic [1:0]           status_q;

  logic [CoordBits-1:0] c_start [N];
  logic [CoordBits:0]   c_end   [N];
  logic [CoordBits-1:0] c_height[N];
  logic                 c_valid [N], c_hit[N];
  cell_sel_t            c_sel   [N];

  // latched classification
  logic [CoordBits-1:0] gmax_q [NG];
  logic [IW-1:0]        first_q, last_q, cnt_q, del_q;
  logic                 sl_q, sr_q;

  assign busy     = (st_q != StIdle);
  assign done_o   = done_q;
  assign base_y_o = base_q;
  assign top_y_o  = top_q;
  assign status_o = status_q;

  // cell row
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int unsigned P1 = (k >= 1) ? k - 1 : 0;
    localparam int unsigned P2 = (k >= 2) ? k - 2 : 0;
    localparam int unsigned N1 = (k + 1 < N) ? k + 1 : k;
    scp_cell #(.CoordBits(CoordBits), .IsFirst(k == 0)) u_cell (
      .clk_i, .rst_ni,
      .init_i     (st_q == StInit),
      .xl_i       (xl_q), .xr_i(xr_q), .top_i(top_q),
      .p1_start_i (c_start[P1]), .p2_start_i(c_start[P2]),
      .p1_end_i   (c_end[P1]),   .p2_end_i  (c_end[P2]),
      .p1_height_i(c_height[P1]), .p2_height_i(c_height[P2]),
      .p1_valid_i (k >= 1 ? c_valid[P1] : 1'b0),
      .p2_valid_i (k >= 2 ? c_valid[P2] : 1'b0),
      .n1_start_i (c_start[N1]), .n1_end_i(c_end[N1]),
      .n1_height_i(c_height[N1]),
      .n1_valid_i (k + 1 < N ? c_valid[N1] : 1'b0),
      .sel_i      (c_sel[k]),
      .start_o    (c_start[k]), .end_o(c_end[k]), .height_o(c_height[k]),
      .valid_o    (c_valid[k]), .hit_o(c_hit[k])
    );
  end

  // classify cycle: hits, first/last index, count, edge splits, group maxima
  logic [IW-1:0] first_c, last_c, cnt_c;
  logic          found_c, sl_c, sr_c;
  logic [CoordBits-1:0] gmax_c [NG];
  always_comb begin
    first_c = '0; last_c = '0; cnt_c = '0; found_c = 1'b0;
    sl_c = 1'b0; sr_c = 1'b0;
    for (int unsigned k = 0; k < N; k++) begin
      if (c_valid[k]) cnt_c = IW'(k + 1);
      if (c_hit[k] && !found_c) begin first_c = IW'(k); found_c = 1'b1; end
      if (c_hit[k]) last_c = IW'(k);
      // only the first hit can start left of xl, only the last end right of xr
      if (c_hit[k] && c_start[k] < xl_q) sl_c = 1'b1;
      if (c_hit[k] && c_end[k] > {1'b0, xr_q}) sr_c = 1'b1;
    end
    for (int unsigned g = 0; g < NG; g++) begin
      gmax_c[g] = '0;
      for (int unsigned j = 0; j < G; j++)
        if (g * G + j < N)
          if (c_hit[g * G + j] && c_height[g * G + j] > gmax_c[g])
            gmax_c[g] = c_height[g * G + j];
    end
  end

  // max over groups, top and new count
  logic [CoordBits-1:0] base_c;
  logic [CoordBits:0]   top_c;
  logic [W-1:0]         newcnt_c;
  always_comb begin
    base_c = '0;
    for (int unsigned g = 0; g < NG; g++)
      if (gmax_q[g] > base_c) base_c = gmax_q[g];
    top_c    = {1'b0, base_c} + {1'b0, hb_q};
    newcnt_c = W'(cnt_q) - W'(last_q) + W'(first_q) + W'(sl_q) + W'(sr_q);
  end

  // covered span vs pieces written: grow shifts the tail right in the write
  // cycle, otherwise del_c stale cells are removed by left shifts
  logic [IW-1:0] span_c, ins_c, del_c;
  logic          grow_c, two_c;
  always_comb begin
    span_c = last_q - first_q;
    ins_c  = IW'(sl_q) + IW'(sr_q);
    grow_c = (ins_c > span_c);
    two_c  = sl_q && sr_q && (span_c == '0);
    del_c  = span_c - ins_c;
  end

  // rewrite selects: left piece at first, block after it, right piece next
  // (grow) or in place at last; the tail follows
  logic [W-1:0] fpos_c, bpos_c, rpos_c, tail_c, lpos_c;
  always_comb begin
    fpos_c = W'(first_q);
    bpos_c = fpos_c + W'(sl_q);
    rpos_c = bpos_c + W'(1);
    tail_c = rpos_c + W'(sr_q);
    lpos_c = W'(last_q);
    for (int unsigned k = 0; k < N; k++) begin
      c_sel[k] = SelHold;
      if (st_q == StWrite && status_q == StatusOk) begin
        if (W'(k) < fpos_c) c_sel[k] = SelHold;
        else if (sl_q && W'(k) == fpos_c) c_sel[k] = SelOwnL;
        else if (W'(k) == bpos_c) c_sel[k] = SelBlock;
        else if (grow_c) begin
          if (sr_q && W'(k) == rpos_c) c_sel[k] = two_c ? SelRightP2 : SelRightP1;
          else if (W'(k) >= tail_c) c_sel[k] = two_c ? SelP2 : SelP1;
        end else if (sr_q && W'(k) == lpos_c) c_sel[k] = SelOwnR;
      end else if (st_q == StShift && W'(k) >= rpos_c) begin
        c_sel[k] = SelN1;
      end
    end
  end

  // control state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (start) begin
          if (req_type_i == ReqClear) st_d = StInit;
          else if (x_right_i <= x_left_i) st_d = StWrite;
          else st_d = StClass;
        end
      end
      StClass: st_d = StMax;
      StMax:   st_d = StWrite;
      StWrite: st_d = (status_q == StatusOk && !grow_c && del_c != '0) ? StShift : StIdle;
      StShift: st_d = (del_q == IW'(1)) ? StIdle : StShift;
      StInit:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign done_d = (st_q != StIdle) && (st_d == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; done_q <= 1'b0; status_q <= StatusOk;
      base_q <= '0; top_q <= '0;
      xl_q <= '0; xr_q <= '0; hb_q <= '0;
      first_q <= '0; last_q <= '0; cnt_q <= '0; del_q <= '0;
      sl_q <= 1'b0; sr_q <= 1'b0;
      for (int unsigned g = 0; g < NG; g++) gmax_q[g] <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      unique case (st_q)
        StIdle: begin
          if (start) begin
            xl_q <= x_left_i; xr_q <= x_right_i; hb_q <= block_height_i;
            base_q <= '0; top_q <= '0;
            status_q <= (req_type_i == ReqPlace && x_right_i <= x_left_i) ?
                        StatusOverflow : StatusOk;
          end
        end
        StClass: begin
          first_q <= found_c ? first_c : cnt_c - IW'(1);
          last_q  <= found_c ? last_c  : cnt_c - IW'(1);
          cnt_q   <= cnt_c;
          for (int unsigned g = 0; g < NG; g++) gmax_q[g] <= gmax_c[g];
          sl_q <= found_c && sl_c;
          sr_q <= found_c && sr_c;
        end
        StMax: begin
          base_q <= base_c;
          if (top_c[CoordBits]) begin
            top_q <= '1; status_q <= StatusOverflow;
          end else begin
            top_q <= top_c[CoordBits-1:0];
            if (newcnt_c > W'(N)) status_q <= StatusFull;
          end
        end
        StWrite: del_q <= del_c;
        StShift: del_q <= del_q - IW'(1);
        default: ;
      endcase
    end
  end
endmodule

FILE: sv/scp_checker.sv
// Port-level checker for the skyline contour place unit, bound to the top.
// Depends on scp_pkg.
`timescale 1ns / 1ps
module scp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o
);
  import scp_pkg::*;
  // a result comes as the job closes
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy with done");
  // an accepted request makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");
  // status is never the unused code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= StatusOverflow)) else $error("bad status");
  // no result without a job in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("stray result");
endmodule

bind skyline_contour_place_unit scp_checker u_scp_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o
);
